// ===== hdl/rqy_pkg.sv =====
// Shared types, register indexes and arithmetic helpers for the
// RGB 2x2 block to YCbCr 4:2:0 converter. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rqy_pkg;

    localparam int unsigned CFG_INDEX_W = 4;
    localparam int unsigned CFG_DATA_W  = 16;
    localparam int unsigned LUMA_SUM_W  = 16;
    localparam int unsigned CHROMA_SUM_W = 18;
    localparam int unsigned LUMA_SHIFT  = 8;
    localparam int unsigned CHROMA_SHIFT = 10;

    localparam logic [7:0] LUMA_OFFSET   = 8'd16;
    localparam logic [7:0] CHROMA_OFFSET = 8'd128;

    localparam logic [CFG_INDEX_W-1:0] CFG_LUMA_RED     = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_LUMA_GREEN   = 4'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_LUMA_BLUE    = 4'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_CB_RED       = 4'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_CB_GREEN     = 4'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_CHROMA_MAJOR = 4'd5;
    localparam logic [CFG_INDEX_W-1:0] CFG_CR_GREEN     = 4'd6;
    localparam logic [CFG_INDEX_W-1:0] CFG_CR_BLUE      = 4'd7;

    localparam logic signed [15:0] RST_LUMA_RED     = 16'sd66;
    localparam logic signed [15:0] RST_LUMA_GREEN   = 16'sd129;
    localparam logic signed [15:0] RST_LUMA_BLUE    = 16'sd25;
    localparam logic signed [15:0] RST_CB_RED       = -16'sd38;
    localparam logic signed [15:0] RST_CB_GREEN     = -16'sd74;
    localparam logic signed [15:0] RST_CHROMA_MAJOR = 16'sd112;
    localparam logic signed [15:0] RST_CR_GREEN     = -16'sd94;
    localparam logic signed [15:0] RST_CR_BLUE      = -16'sd18;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } pixel_t;

    typedef struct packed {
        pixel_t top_left;
        pixel_t top_right;
        pixel_t bottom_left;
        pixel_t bottom_right;
    } quad_t;

    typedef struct packed {
        logic signed [15:0] luma_red;
        logic signed [15:0] luma_green;
        logic signed [15:0] luma_blue;
        logic signed [15:0] cb_red;
        logic signed [15:0] cb_green;
        logic signed [15:0] chroma_major;
        logic signed [15:0] cr_green;
        logic signed [15:0] cr_blue;
    } gains_t;

    typedef struct packed {
        logic [7:0] luma_top_left;
        logic [7:0] luma_top_right;
        logic [7:0] luma_bottom_left;
        logic [7:0] luma_bottom_right;
        logic [7:0] chroma_blue_diff;
        logic [7:0] chroma_red_diff;
    } result_t;

    // Low bits of gain times sample; only these reach the luma output.
    function automatic logic [LUMA_SUM_W-1:0] luma_term(
        input logic signed [15:0] gain,
        input logic [7:0]         sample
    );
        logic [23:0] prod;
        prod = {8'd0, gain} * {16'd0, sample};
        return prod[LUMA_SUM_W-1:0];
    endfunction

    // Low bits of sign-extended gain times a four-pixel channel sum.
    function automatic logic [CHROMA_SUM_W-1:0] chroma_term(
        input logic signed [15:0] gain,
        input logic [9:0]         sum
    );
        logic [27:0] prod;
        prod = {{12{gain[15]}}, gain} * {18'd0, sum};
        return prod[CHROMA_SUM_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== hdl/rgb_quad_to_yuv420_core.sv =====
// Top level of the RGB 2x2 block to YCbCr 4:2:0 converter: gain registers,
// input word register and result register. Depends on rqy_pkg, rqy_convert.
`timescale 1ns / 1ps
`default_nettype none

// One 2x2 RGB block is taken per clock while in_ready is high, and its four
// luma samples and shared Cb/Cr pair come out of the result register: the
// block is registered on entry, converted by one pass of small multipliers
// and adders, and held in the result register until taken. With out_ready
// high the block accepts a word every cycle; a stalled result holds the entry
// word, and in_ready drops only when both registers are full and out_ready is
// low. Results wrap to 8 bits with no rounding or clamping. The user must
// write gains via cfg_write/cfg_index/cfg_data only while no word is in flight;
// the block does not enforce it. Indexes beyond the eight gains are ignored.
module rgb_quad_to_yuv420_core (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_write,
    input  wire logic [rqy_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [rqy_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  wire logic                             in_valid,
    output logic                                  in_ready,
    input  wire logic [7:0]                       top_left_red,
    input  wire logic [7:0]                       top_left_green,
    input  wire logic [7:0]                       top_left_blue,
    input  wire logic [7:0]                       top_right_red,
    input  wire logic [7:0]                       top_right_green,
    input  wire logic [7:0]                       top_right_blue,
    input  wire logic [7:0]                       bottom_left_red,
    input  wire logic [7:0]                       bottom_left_green,
    input  wire logic [7:0]                       bottom_left_blue,
    input  wire logic [7:0]                       bottom_right_red,
    input  wire logic [7:0]                       bottom_right_green,
    input  wire logic [7:0]                       bottom_right_blue,
    output logic                                  out_valid,
    input  wire logic                             out_ready,
    output logic [7:0]                            luma_top_left,
    output logic [7:0]                            luma_top_right,
    output logic [7:0]                            luma_bottom_left,
    output logic [7:0]                            luma_bottom_right,
    output logic [7:0]                            chroma_blue_diff,
    output logic [7:0]                            chroma_red_diff
);
    import rqy_pkg::*;

    gains_t  gains_reg;
    gains_t  gains_next;
    quad_t   quad_reg;
    logic    quad_valid_reg;
    result_t result_reg;
    logic    out_valid_reg;
    result_t result_next;
    logic    quad_advance;
    logic    in_accept;

    assign quad_advance = quad_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready     = !quad_valid_reg || !out_valid_reg || out_ready;
    assign in_accept    = in_valid && in_ready;

    always_comb
    begin
        gains_next = gains_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                CFG_LUMA_RED:     gains_next.luma_red     = cfg_data;
                CFG_LUMA_GREEN:   gains_next.luma_green   = cfg_data;
                CFG_LUMA_BLUE:    gains_next.luma_blue    = cfg_data;
                CFG_CB_RED:       gains_next.cb_red       = cfg_data;
                CFG_CB_GREEN:     gains_next.cb_green     = cfg_data;
                CFG_CHROMA_MAJOR: gains_next.chroma_major = cfg_data;
                CFG_CR_GREEN:     gains_next.cr_green     = cfg_data;
                CFG_CR_BLUE:      gains_next.cr_blue      = cfg_data;
                default:          gains_next = gains_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gains_reg.luma_red     <= RST_LUMA_RED;
            gains_reg.luma_green   <= RST_LUMA_GREEN;
            gains_reg.luma_blue    <= RST_LUMA_BLUE;
            gains_reg.cb_red       <= RST_CB_RED;
            gains_reg.cb_green     <= RST_CB_GREEN;
            gains_reg.chroma_major <= RST_CHROMA_MAJOR;
            gains_reg.cr_green     <= RST_CR_GREEN;
            gains_reg.cr_blue      <= RST_CR_BLUE;
            quad_valid_reg         <= 1'b0;
            out_valid_reg          <= 1'b0;
        end
        else
        begin
            gains_reg <= gains_next;
            if (in_accept)
                quad_valid_reg <= 1'b1;
            else if (quad_advance)
                quad_valid_reg <= 1'b0;
            if (quad_advance)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            quad_reg.top_left     <= '{top_left_red, top_left_green, top_left_blue};
            quad_reg.top_right    <= '{top_right_red, top_right_green, top_right_blue};
            quad_reg.bottom_left  <= '{bottom_left_red, bottom_left_green,
                                       bottom_left_blue};
            quad_reg.bottom_right <= '{bottom_right_red, bottom_right_green,
                                       bottom_right_blue};
        end
        if (quad_advance)
            result_reg <= result_next;
    end

    rqy_convert u_convert (
        .quad   (quad_reg),
        .gains  (gains_reg),
        .result (result_next)
    );

    assign out_valid         = out_valid_reg;
    assign luma_top_left     = result_reg.luma_top_left;
    assign luma_top_right    = result_reg.luma_top_right;
    assign luma_bottom_left  = result_reg.luma_bottom_left;
    assign luma_bottom_right = result_reg.luma_bottom_right;
    assign chroma_blue_diff  = result_reg.chroma_blue_diff;
    assign chroma_red_diff   = result_reg.chroma_red_diff;

endmodule

`default_nettype wire

// ===== hdl/rqy_convert.sv =====
// Combinational color conversion of one 2x2 block: four luma samples and
// one shared Cb/Cr pair. Depends on rqy_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rqy_convert (
    input  rqy_pkg::quad_t   quad,
    input  rqy_pkg::gains_t  gains,
    output rqy_pkg::result_t result
);
    import rqy_pkg::*;

    pixel_t                  pix [4];
    logic [LUMA_SUM_W-1:0]   luma_sum [4];
    logic [7:0]              luma [4];
    logic [9:0]              sum_red;
    logic [9:0]              sum_green;
    logic [9:0]              sum_blue;
    logic [CHROMA_SUM_W-1:0] cb_sum;
    logic [CHROMA_SUM_W-1:0] cr_sum;

    assign pix[0] = quad.top_left;
    assign pix[1] = quad.top_right;
    assign pix[2] = quad.bottom_left;
    assign pix[3] = quad.bottom_right;

    always_comb
    begin
        for (int p = 0; p < 4; p++)
        begin
            luma_sum[p] = luma_term(gains.luma_red, pix[p].red)
                        + luma_term(gains.luma_green, pix[p].green)
                        + luma_term(gains.luma_blue, pix[p].blue);
            luma[p] = luma_sum[p][LUMA_SHIFT +: 8] + LUMA_OFFSET;
        end
    end

    assign sum_red   = {2'd0, pix[0].red} + {2'd0, pix[1].red}
                     + {2'd0, pix[2].red} + {2'd0, pix[3].red};
    assign sum_green = {2'd0, pix[0].green} + {2'd0, pix[1].green}
                     + {2'd0, pix[2].green} + {2'd0, pix[3].green};
    assign sum_blue  = {2'd0, pix[0].blue} + {2'd0, pix[1].blue}
                     + {2'd0, pix[2].blue} + {2'd0, pix[3].blue};

    assign cb_sum = chroma_term(gains.cb_red, sum_red)
                  + chroma_term(gains.cb_green, sum_green)
                  + chroma_term(gains.chroma_major, sum_blue);
    assign cr_sum = chroma_term(gains.chroma_major, sum_red)
                  + chroma_term(gains.cr_green, sum_green)
                  + chroma_term(gains.cr_blue, sum_blue);

    assign result.luma_top_left     = luma[0];
    assign result.luma_top_right    = luma[1];
    assign result.luma_bottom_left  = luma[2];
    assign result.luma_bottom_right = luma[3];
    assign result.chroma_blue_diff  = cb_sum[CHROMA_SHIFT +: 8] + CHROMA_OFFSET;
    assign result.chroma_red_diff   = cr_sum[CHROMA_SHIFT +: 8] + CHROMA_OFFSET;

endmodule

`default_nettype wire

// ===== hdl/rqy_checker.sv =====
// Port-level checks for rgb_quad_to_yuv420_core and the bind that attaches
// them. Depends on rgb_quad_to_yuv420_core.
`timescale 1ns / 1ps
`default_nettype none

module rqy_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_valid,
    input wire logic       in_ready,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic [7:0] luma_top_left,
    input wire logic [7:0] luma_top_right,
    input wire logic [7:0] luma_bottom_left,
    input wire logic [7:0] luma_bottom_right,
    input wire logic [7:0] chroma_blue_diff,
    input wire logic [7:0] chroma_red_diff
);

    // Hold a stalled result word.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result word dropped while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable({luma_top_left, luma_top_right,
            luma_bottom_left, luma_bottom_right, chroma_blue_diff,
            chroma_red_diff}))
        else $error("stalled result word changed");

    // Keep accepting while the result side drains.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_ready || !out_valid |-> in_ready)
        else $error("input stalled while result side can drain");

    // A fresh result follows an accepted word through the entry and result registers.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready, 2))
        else $error("result word without matching input word");

endmodule

bind rgb_quad_to_yuv420_core rqy_checker u_rqy_checker (.*);

`default_nettype wire

// ===== test/tb_rgb_quad_to_yuv420_core.sv =====
// Testbench for rgb_quad_to_yuv420_core: directed and random 2x2 RGB blocks
// under several gain settings, each result checked against a scoreboard.
// Depends on rqy_pkg and rgb_quad_to_yuv420_core.
`timescale 1ns / 1ps

import rqy_pkg::*;

class yuv_scoreboard;
    localparam int NUM_GAINS = 8;

    logic [15:0] gains [NUM_GAINS];
    result_t     expected_q [$];
    int          errors;

    function new();
        gains[CFG_LUMA_RED]     = RST_LUMA_RED;
        gains[CFG_LUMA_GREEN]   = RST_LUMA_GREEN;
        gains[CFG_LUMA_BLUE]    = RST_LUMA_BLUE;
        gains[CFG_CB_RED]       = RST_CB_RED;
        gains[CFG_CB_GREEN]     = RST_CB_GREEN;
        gains[CFG_CHROMA_MAJOR] = RST_CHROMA_MAJOR;
        gains[CFG_CR_GREEN]     = RST_CR_GREEN;
        gains[CFG_CR_BLUE]      = RST_CR_BLUE;
        errors = 0;
    endfunction

    function void set_gain(input logic [CFG_INDEX_W-1:0] idx, input logic [15:0] value);
        if (idx < NUM_GAINS)
            gains[idx[2:0]] = value;
    endfunction

    function int pending();
        return expected_q.size();
    endfunction

    function logic [31:0] widen(input logic [15:0] g);
        return {{16{g[15]}}, g};
    endfunction

    function logic [31:0] weigh(input logic [15:0] gr, input logic [15:0] gg,
                                input logic [15:0] gb, input logic [31:0] r,
                                input logic [31:0] g, input logic [31:0] b);
        return widen(gr) * r + widen(gg) * g + widen(gb) * b;
    endfunction

    function logic [7:0] luma_of(input pixel_t p);
        logic [31:0] s;
        s = weigh(gains[CFG_LUMA_RED], gains[CFG_LUMA_GREEN], gains[CFG_LUMA_BLUE],
                  32'(p.red), 32'(p.green), 32'(p.blue));
        return s[LUMA_SHIFT +: 8] + LUMA_OFFSET;
    endfunction

    function void note_quad(input quad_t q);
        result_t     r;
        logic [31:0] sr;
        logic [31:0] sg;
        logic [31:0] sb;
        logic [31:0] s;
        sr = 32'(q.top_left.red) + 32'(q.top_right.red)
           + 32'(q.bottom_left.red) + 32'(q.bottom_right.red);
        sg = 32'(q.top_left.green) + 32'(q.top_right.green)
           + 32'(q.bottom_left.green) + 32'(q.bottom_right.green);
        sb = 32'(q.top_left.blue) + 32'(q.top_right.blue)
           + 32'(q.bottom_left.blue) + 32'(q.bottom_right.blue);
        r.luma_top_left     = luma_of(q.top_left);
        r.luma_top_right    = luma_of(q.top_right);
        r.luma_bottom_left  = luma_of(q.bottom_left);
        r.luma_bottom_right = luma_of(q.bottom_right);
        s = weigh(gains[CFG_CB_RED], gains[CFG_CB_GREEN], gains[CFG_CHROMA_MAJOR], sr, sg, sb);
        r.chroma_blue_diff = s[CHROMA_SHIFT +: 8] + CHROMA_OFFSET;
        s = weigh(gains[CFG_CHROMA_MAJOR], gains[CFG_CR_GREEN], gains[CFG_CR_BLUE], sr, sg, sb);
        r.chroma_red_diff = s[CHROMA_SHIFT +: 8] + CHROMA_OFFSET;
        expected_q.push_back(r);
    endfunction

    function void compare(input string name, input logic [7:0] want, input logic [7:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endfunction

    function void check_result(input result_t got);
        result_t want;
        if (expected_q.size() == 0)
        begin
            $error("result word %h with nothing expected", got);
            errors++;
            return;
        end
        want = expected_q.pop_front();
        compare("luma_top_left", want.luma_top_left, got.luma_top_left);
        compare("luma_top_right", want.luma_top_right, got.luma_top_right);
        compare("luma_bottom_left", want.luma_bottom_left, got.luma_bottom_left);
        compare("luma_bottom_right", want.luma_bottom_right, got.luma_bottom_right);
        compare("chroma_blue_diff", want.chroma_blue_diff, got.chroma_blue_diff);
        compare("chroma_red_diff", want.chroma_red_diff, got.chroma_red_diff);
    endfunction
endclass

module tb_rgb_quad_to_yuv420_core;

    localparam int NUM_GAINS        = 8;
    localparam int NUM_PHASES       = 7;
    localparam int RANDOM_PER_PHASE = 100;
    localparam int HOLD_CYCLES      = 60;
    localparam int DRAIN_CYCLES     = 4;

    localparam logic [CFG_INDEX_W-1:0] GAIN_INDEX [NUM_GAINS] = '{
        CFG_LUMA_RED, CFG_LUMA_GREEN, CFG_LUMA_BLUE, CFG_CB_RED,
        CFG_CB_GREEN, CFG_CHROMA_MAJOR, CFG_CR_GREEN, CFG_CR_BLUE
    };
    localparam logic [15:0] DEFAULT_GAINS [NUM_GAINS] = '{
        RST_LUMA_RED, RST_LUMA_GREEN, RST_LUMA_BLUE, RST_CB_RED,
        RST_CB_GREEN, RST_CHROMA_MAJOR, RST_CR_GREEN, RST_CR_BLUE
    };

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_write;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   in_valid;
    wire logic              in_ready;
    quad_t                  quad;
    wire logic              out_valid;
    logic                   out_ready;
    wire result_t           result;

    int send_idle_pct;
    int recv_stall_pct;
    bit hold_req;

    yuv_scoreboard sb = new();

    rgb_quad_to_yuv420_core u_dut (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg_write          (cfg_write),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .in_valid           (in_valid),
        .in_ready           (in_ready),
        .top_left_red       (quad.top_left.red),
        .top_left_green     (quad.top_left.green),
        .top_left_blue      (quad.top_left.blue),
        .top_right_red      (quad.top_right.red),
        .top_right_green    (quad.top_right.green),
        .top_right_blue     (quad.top_right.blue),
        .bottom_left_red    (quad.bottom_left.red),
        .bottom_left_green  (quad.bottom_left.green),
        .bottom_left_blue   (quad.bottom_left.blue),
        .bottom_right_red   (quad.bottom_right.red),
        .bottom_right_green (quad.bottom_right.green),
        .bottom_right_blue  (quad.bottom_right.blue),
        .out_valid          (out_valid),
        .out_ready          (out_ready),
        .luma_top_left      (result.luma_top_left),
        .luma_top_right     (result.luma_top_right),
        .luma_bottom_left   (result.luma_bottom_left),
        .luma_bottom_right  (result.luma_bottom_right),
        .chroma_blue_diff   (result.chroma_blue_diff),
        .chroma_red_diff    (result.chroma_red_diff)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("TEST FAILED");
        $finish;
    end

    function automatic logic [7:0] random_sample();
        case ($urandom_range(7))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    function automatic quad_t random_quad();
        quad_t q;
        for (int f = 0; f < 12; f++)
            q[f*8 +: 8] = random_sample();
        return q;
    endfunction

    function automatic logic [15:0] gain_value(input int phase, input int i);
        case (phase)
            1: return 16'h7FFF;
            2: return 16'h8000;
            3: return 16'($urandom_range(65535));
            4: return (i % 2) ? 16'h8000 : 16'h7FFF;
            5: return 16'h0000;
            default: return DEFAULT_GAINS[i];
        endcase
    endfunction

    task automatic send_quad(input quad_t q);
        bit taken;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        quad     <= q;
        taken = 1'b0;
        while (!taken)
        begin
            @(negedge clk);
            taken = in_ready;
            @(posedge clk);
        end
        sb.note_quad(q);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_gains(input int phase);
        logic [15:0] value;
        for (int i = 0; i < NUM_GAINS; i++)
        begin
            value = gain_value(phase, i);
            cfg_write <= 1'b1;
            cfg_index <= GAIN_INDEX[i];
            cfg_data  <= value;
            sb.set_gain(GAIN_INDEX[i], value);
            @(posedge clk);
        end
        // stray index past the gains: must leave them untouched
        cfg_index <= CFG_INDEX_W'($urandom_range(2**CFG_INDEX_W - 1, NUM_GAINS));
        cfg_data  <= CFG_DATA_W'($urandom);
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic run_directed();
        quad_t q;
        send_quad('0);
        send_quad('1);
        send_quad({4{24'hAAAAAA}});
        send_quad({4{24'h555555}});
        for (int f = 0; f < 12; f++)
        begin
            q = '0;
            q[f*8 +: 8] = 8'hFF;
            send_quad(q);
        end
        for (int c = 0; c < 3; c++)
        begin
            q = '0;
            for (int p = 0; p < 4; p++)
                q[p*24 + c*8 +: 8] = 8'hFF;
            send_quad(q);
        end
    endtask

    task automatic set_idling(input int phase);
        if (phase < 2)
        begin
            send_idle_pct  = 18;
            recv_stall_pct = 48;
        end
        else if (phase < 4)
        begin
            send_idle_pct  = 48;
            recv_stall_pct = 18;
        end
        else
        begin
            send_idle_pct  = 0;
            recv_stall_pct = 0;
        end
    endtask

    initial
    begin
        out_ready = 1'b0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            else
                out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    initial
    begin
        forever
        begin
            @(negedge clk);
            if (rst_n && out_valid && out_ready)
                sb.check_result(result);
        end
    end

    initial
    begin
        rst_n          = 1'b0;
        cfg_write      = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        in_valid       = 1'b0;
        quad           = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_req       = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            set_idling(phase);
            if (phase == 0)
                run_directed();
            else
            begin
                drain();
                write_gains(phase);
            end
            if (phase == 1)
                hold_req = 1'b1;
            for (int n = 0; n < RANDOM_PER_PHASE; n++)
            begin
                if (phase == 5 && n == RANDOM_PER_PHASE / 2)
                    drain();
                send_quad(random_quad());
            end
        end
        drain();

        if (sb.errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/rqy_pkg.sv
hdl/rqy_convert.sv
hdl/rgb_quad_to_yuv420_core.sv
hdl/rqy_checker.sv
test/tb_rgb_quad_to_yuv420_core.sv
